### sv/fpvs_pkg.sv
// ----------------------------------------------------------------------------
// fpvs_pkg
// Shared types and constants for the FM channel pitch/volume slide unit.
// ----------------------------------------------------------------------------
package fpvs_pkg;

  // Pitch format limits
  localparam logic [9:0] FNUM_MAX   = 10'h3FF;
  localparam logic [9:0] FNUM_LOW   = 10'h156;
  localparam logic [9:0] FNUM_HIGH  = 10'h2AE;
  localparam logic [9:0] FNUM_SHIFT = FNUM_HIGH - FNUM_LOW;
  localparam logic [2:0] BLOCK_MAX  = 3'd7;

  // Volume slide limits
  localparam logic [5:0] LEVEL_MAX  = 6'd63;
  localparam logic [7:0] VOL_SPLIT  = 8'd50;
  localparam logic [7:0] VOL_LIMIT  = 8'd100;

  // Operation codes
  typedef enum logic [2:0] {
    OP_LOAD_PITCH   = 3'd0,
    OP_SET_TARGET   = 3'd1,
    OP_SLIDE_BY     = 3'd2,
    OP_SLIDE_TARGET = 3'd3,
    OP_VOLUME_SLIDE = 3'd4,
    OP_SET_LEVEL    = 3'd5,
    OP_SLIDE_VOLUME = 3'd6,
    OP_UNUSED       = 3'd7
  } op_t;

  // Block plus F-number; packed so that a compare orders block first
  typedef struct packed {
    logic [2:0] block;
    logic [9:0] fnum;
  } pitch_t;

endpackage

### sv/fpvs_pitch.sv
// ----------------------------------------------------------------------------
// fpvs_pitch
// One signed F-number step with clamp and octave block carry/borrow.
// ----------------------------------------------------------------------------
module fpvs_pitch (
  input  fpvs_pkg::pitch_t    cur,
  input  logic signed [8:0]   delta,
  output fpvs_pkg::pitch_t    nxt
);

  logic signed [11:0] f_sum;
  logic [9:0]         f_clamp;

  // Add the step, range -256..1278
  assign f_sum = $signed({2'b00, cur.fnum}) + $signed({{3{delta[8]}}, delta});

  // Clamp to 0..1023
  always_comb begin
    if (f_sum[11]) begin
      f_clamp = '0;
    end else if (f_sum[10]) begin
      f_clamp = fpvs_pkg::FNUM_MAX;
    end else begin
      f_clamp = f_sum[9:0];
    end
  end

  // Move the block when the F-number leaves the octave window
  always_comb begin
    nxt.block = cur.block;
    nxt.fnum  = f_clamp;
    if (f_clamp < fpvs_pkg::FNUM_LOW) begin
      if (cur.block != 3'd0) begin
        nxt.block = cur.block - 3'd1;
        nxt.fnum  = f_clamp + fpvs_pkg::FNUM_SHIFT;
      end
    end else if (f_clamp > fpvs_pkg::FNUM_HIGH) begin
      if (cur.block != fpvs_pkg::BLOCK_MAX) begin
        nxt.block = cur.block + 3'd1;
        nxt.fnum  = f_clamp - fpvs_pkg::FNUM_SHIFT;
      end
    end
  end

endmodule

### sv/fpvs_level.sv
// ----------------------------------------------------------------------------
// fpvs_level
// Volume slide: saturating add or subtract of the carrier level by code.
// ----------------------------------------------------------------------------
module fpvs_level (
  input  logic [5:0] level,
  input  logic [7:0] code,
  output logic [5:0] level_nxt
);

  logic [6:0] up_sum;
  logic [7:0] down_full;
  logic [5:0] down_amt;

  assign up_sum    = {1'b0, level} + {1'b0, code[5:0]};
  assign down_full = code - fpvs_pkg::VOL_SPLIT;
  assign down_amt  = down_full[5:0];

  // Codes 1..49 go up, 51..99 go down by code minus 50, others hold
  always_comb begin
    level_nxt = level;
    if (code inside {[8'd1 : fpvs_pkg::VOL_SPLIT - 8'd1]}) begin
      level_nxt = up_sum[6] ? fpvs_pkg::LEVEL_MAX : up_sum[5:0];
    end else if (code inside {[fpvs_pkg::VOL_SPLIT + 8'd1 : fpvs_pkg::VOL_LIMIT - 8'd1]}) begin
      level_nxt = (down_amt >= level) ? 6'd0 : level - down_amt;
    end
  end

endmodule

### sv/fm_channel_pitch_volume_slide.sv
// ----------------------------------------------------------------------------
// fm_channel_pitch_volume_slide
// Timing: the start beat passes through the input register, then the result register raises out_valid.
// Throughput: one item per cycle; busy is never raised, the channel state is
// updated in the same edge that loads the result register.
// Reset: synchronous active-low rst_n clears all channel state and strobes.
// ----------------------------------------------------------------------------
module fm_channel_pitch_volume_slide #(
  parameter int NUM_CHANNELS = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  // Command channel
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_operation,
  input  logic [3:0]        in_chan,
  input  logic signed [8:0] in_slide_amount,
  input  logic [7:0]        in_volume_step,
  input  logic [2:0]        in_block_value,
  input  logic [9:0]        in_fnumber_value,
  input  logic [5:0]        in_level_value,
  input  logic [7:0]        in_speed_value,
  // Result channel
  output logic              out_valid,
  output logic [3:0]        out_chan_out,
  output logic [2:0]        out_block_out,
  output logic [9:0]        out_fnumber_out,
  output logic [5:0]        out_level_out
);

  localparam int         IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [4:0] NCH   = NUM_CHANNELS[4:0];

  // Input register
  logic              in_valid_r;
  fpvs_pkg::op_t     op_r;
  logic [3:0]        chan_r;
  logic signed [8:0] amount_r;
  logic [7:0]        vstep_r;
  logic [2:0]        bval_r;
  logic [9:0]        fval_r;
  logic [5:0]        lval_r;
  logic [7:0]        sval_r;

  // Per-channel state
  logic [2:0] chan_block_r     [NUM_CHANNELS];
  logic [9:0] chan_fnumber_r   [NUM_CHANNELS];
  logic [5:0] chan_level_r     [NUM_CHANNELS];
  logic [2:0] target_block_r   [NUM_CHANNELS];
  logic [9:0] target_fnumber_r [NUM_CHANNELS];
  logic [7:0] slide_rate_r     [NUM_CHANNELS];

  // Result register
  logic       out_valid_r;
  logic [3:0] out_chan_r;
  logic [2:0] out_block_r;
  logic [9:0] out_fnumber_r;
  logic [5:0] out_level_r;

  logic                 in_range;
  logic [IDX_W-1:0]     idx;
  fpvs_pkg::pitch_t     cur_pitch;
  fpvs_pkg::pitch_t     tgt_pitch;
  fpvs_pkg::pitch_t     step_pitch;
  fpvs_pkg::pitch_t     slid_pitch;
  fpvs_pkg::pitch_t     pitch_nxt;
  logic [7:0]           cur_rate;
  logic [5:0]           cur_level;
  logic [5:0]           vol_level;
  logic [5:0]           level_nxt;
  logic                 slide_up;
  logic                 slide_down;
  logic signed [8:0]    delta;
  logic                 wr_en;
  logic                 tgt_wr;

  assign busy = 1'b0;

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= fpvs_pkg::op_t'(in_operation);
    chan_r   <= in_chan;
    amount_r <= in_slide_amount;
    vstep_r  <= in_volume_step;
    bval_r   <= in_block_value;
    fval_r   <= in_fnumber_value;
    lval_r   <= in_level_value;
    sval_r   <= in_speed_value;
  end

  // Channel state read
  assign in_range = {1'b0, chan_r} < NCH;
  assign idx      = chan_r[IDX_W-1:0];

  always_comb begin
    cur_pitch = '0;
    tgt_pitch = '0;
    cur_rate  = '0;
    cur_level = '0;
    if (in_range) begin
      cur_pitch.block = chan_block_r[idx];
      cur_pitch.fnum  = chan_fnumber_r[idx];
      tgt_pitch.block = target_block_r[idx];
      tgt_pitch.fnum  = target_fnumber_r[idx];
      cur_rate        = slide_rate_r[idx];
      cur_level       = chan_level_r[idx];
    end
  end

  // Slide direction and step size
  assign slide_up   = cur_pitch < tgt_pitch;
  assign slide_down = cur_pitch > tgt_pitch;

  always_comb begin
    if (op_r == fpvs_pkg::OP_SLIDE_BY) begin
      delta = amount_r;
    end else if (slide_up) begin
      delta = $signed({1'b0, cur_rate});
    end else begin
      delta = -$signed({1'b0, cur_rate});
    end
  end

  fpvs_pitch u_pitch (
    .cur   (cur_pitch),
    .delta (delta),
    .nxt   (step_pitch)
  );

  fpvs_level u_level (
    .level     (cur_level),
    .code      (vstep_r),
    .level_nxt (vol_level)
  );

  // Slide toward target, snapping on reach or overshoot
  always_comb begin
    if ((slide_up && step_pitch >= tgt_pitch) || (slide_down && step_pitch <= tgt_pitch)) begin
      slid_pitch = tgt_pitch;
    end else if (slide_up || slide_down) begin
      slid_pitch = step_pitch;
    end else begin
      slid_pitch = cur_pitch;
    end
  end

  // Operation decode
  always_comb begin
    pitch_nxt = cur_pitch;
    level_nxt = cur_level;
    tgt_wr    = 1'b0;
    case (op_r)
      fpvs_pkg::OP_LOAD_PITCH: begin
        pitch_nxt.block = bval_r;
        pitch_nxt.fnum  = fval_r;
      end
      fpvs_pkg::OP_SET_TARGET: begin
        tgt_wr = 1'b1;
      end
      fpvs_pkg::OP_SLIDE_BY: begin
        pitch_nxt = step_pitch;
      end
      fpvs_pkg::OP_SLIDE_TARGET: begin
        pitch_nxt = slid_pitch;
      end
      fpvs_pkg::OP_VOLUME_SLIDE: begin
        level_nxt = vol_level;
      end
      fpvs_pkg::OP_SET_LEVEL: begin
        level_nxt = lval_r;
      end
      fpvs_pkg::OP_SLIDE_VOLUME: begin
        pitch_nxt = slid_pitch;
        level_nxt = vol_level;
      end
      default: begin
      end
    endcase
  end

  assign wr_en = in_valid_r && in_range;

  // Channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_block_r[i]     <= '0;
        chan_fnumber_r[i]   <= '0;
        chan_level_r[i]     <= '0;
        target_block_r[i]   <= '0;
        target_fnumber_r[i] <= '0;
        slide_rate_r[i]     <= '0;
      end
    end else if (wr_en) begin
      chan_block_r[idx]   <= pitch_nxt.block;
      chan_fnumber_r[idx] <= pitch_nxt.fnum;
      chan_level_r[idx]   <= level_nxt;
      if (tgt_wr) begin
        target_block_r[idx]   <= bval_r;
        target_fnumber_r[idx] <= fval_r;
        slide_rate_r[idx]     <= sval_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  // Channels past the last one report zeros
  always_ff @(posedge clk) begin
    out_chan_r <= chan_r;
    if (in_range) begin
      out_block_r   <= pitch_nxt.block;
      out_fnumber_r <= pitch_nxt.fnum;
      out_level_r   <= level_nxt;
    end else begin
      out_block_r   <= '0;
      out_fnumber_r <= '0;
      out_level_r   <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chan_out    = out_chan_r;
  assign out_block_out   = out_block_r;
  assign out_fnumber_out = out_fnumber_r;
  assign out_level_out   = out_level_r;

`ifndef SYNTHESIS
  // Every result strobe follows a command beat, through the input and result registers
  a_strobe_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without a command beat");

  // Result carries the channel of its own command beat
  a_chan_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chan_out == $past(in_chan, 2))
    else $error("result channel does not match command");

  // Out-of-range channel reports zeros
  a_bad_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ({1'b0, out_chan_out} >= NCH)) |->
      (out_block_out == 3'd0 && out_fnumber_out == 10'd0 && out_level_out == 6'd0))
    else $error("out-of-range channel reported non-zero pitch or level");
`endif

endmodule
